@@ hw/rtl/itoar_pkg.sv @@
// Shared types, constants and helpers for the radix integer-to-text converter.
// No dependencies; used by itoar_div and the top level (itoar_ram does not use it).
package itoar_pkg;

	localparam int BASE_BITS  = 6;
	localparam int DIGIT_BITS = 6;
	localparam int CHAR_BITS  = 7;

	localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;

	localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 6'd9;

	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_A_LC  = 7'h61;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SIGN,
		S_RD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic again;
	} div_cmd_t;

	typedef struct packed {
		logic done;
		logic quot_zero;
	} div_stat_t;

	function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
		logic [BASE_BITS-1:0] r;
		r = b;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end
		return r;
	endfunction

	function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] c;
		if (d > DIGIT_MAX) begin
			c = CHAR_A_LC + CHAR_BITS'(d) - CHAR_BITS'(DIGIT_MAX) - CHAR_BITS'(1);
		end else begin
			c = CHAR_ZERO + CHAR_BITS'(d);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/itoar_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itoar_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/itoar_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, quotient kept in place.
// Depends on itoar_pkg for the command and status structs.
module itoar_div #(
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  itoar_pkg::div_cmd_t              cmd,
	input  logic [WORD_BITS-1:0]             dividend,
	input  logic [itoar_pkg::BASE_BITS-1:0]  divisor,
	output itoar_pkg::div_stat_t             stat,
	output logic [itoar_pkg::DIGIT_BITS-1:0] remainder
);

	localparam int BIT_W = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0]              word_q;
	logic [itoar_pkg::BASE_BITS-1:0]   base_q;
	logic [itoar_pkg::DIGIT_BITS-1:0]  rem_q;
	logic [BIT_W-1:0]                  bit_q;
	logic                              busy_q;
	logic                              done_q;
	logic [itoar_pkg::DIGIT_BITS:0]    trial;
	logic                              qbit;
	logic [itoar_pkg::DIGIT_BITS-1:0]  rem_next;

	// remainder stays below the base, so one extra bit covers the trial value
	always_comb begin
		trial = {rem_q, word_q[WORD_BITS-1]};
		qbit  = trial >= {1'b0, base_q};
		if (qbit) begin
			rem_next = itoar_pkg::DIGIT_BITS'(trial - {1'b0, base_q});
		end else begin
			rem_next = trial[itoar_pkg::DIGIT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.load || cmd.again) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= dividend;
			base_q <= divisor;
			rem_q  <= '0;
			bit_q  <= BIT_W'(WORD_BITS - 1);
		end else if (cmd.again) begin
			rem_q <= '0;
			bit_q <= BIT_W'(WORD_BITS - 1);
		end else if (busy_q) begin
			word_q <= {word_q[WORD_BITS-2:0], qbit};
			rem_q  <= rem_next;
			bit_q  <= bit_q - BIT_W'(1);
		end
	end

	assign stat.done      = done_q;
	assign stat.quot_zero = (word_q == '0);
	assign remainder      = rem_q;

endmodule

@@ hw/rtl/integer_to_ascii_radix_core.sv @@
// Top level of the radix integer-to-text converter.
// Depends on itoar_pkg, itoar_div and itoar_ram.
//
// Converts one WORD_BITS-bit word per item into ASCII text in the radix held in
// the number_base register (written through cfg_data, clamped to 2..36, reset 10);
// base ten prints a '-' and the magnitude for words with the top bit set, other
// bases treat the word as unsigned. Characters leave most significant first, one
// per output word, with last_char set on the final one. The bit-serial divider
// yields the digits least significant first into the digit RAM; they are then
// read back in reverse, each character passing a read state and an emit state,
// after a sign state when a sign is printed. The sign and emit states wait while
// the output is stalled, and no new word is taken until the item is through.
// The next word is taken while the last character still waits in the output
// register. cfg_ready is always high; write the base only while the block is idle.
module integer_to_ascii_radix_core #(
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [itoar_pkg::BASE_BITS-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [WORD_BITS-1:0]             value_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [itoar_pkg::CHAR_BITS-1:0]  char_code,
	output logic                             last_char
);

	localparam int CNT_W  = $clog2(WORD_BITS + 1);
	localparam int ADDR_W = $clog2(WORD_BITS);

	itoar_pkg::state_t                state_q, state_d;
	logic [itoar_pkg::BASE_BITS-1:0]  base_q;
	logic [CNT_W-1:0]                 count_q, count_d, count_dec;
	logic                             neg_q;
	logic                             out_valid_q;
	logic [itoar_pkg::CHAR_BITS-1:0]  char_q;
	logic                             last_q;

	logic                             accept;
	logic                             slot_free;
	logic                             out_load;
	logic [itoar_pkg::CHAR_BITS-1:0]  out_char;
	logic                             out_last;
	logic [itoar_pkg::BASE_BITS-1:0]  eff_base;
	logic                             is_neg;
	logic [WORD_BITS-1:0]             magnitude;

	itoar_pkg::div_cmd_t              div_cmd;
	itoar_pkg::div_stat_t             div_stat;
	logic [itoar_pkg::DIGIT_BITS-1:0] div_rem;
	logic                             ram_we;
	logic [itoar_pkg::DIGIT_BITS-1:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != itoar_pkg::S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign count_dec = count_q - CNT_W'(1);

	assign eff_base  = itoar_pkg::clamp_base(base_q);
	assign is_neg    = (eff_base == itoar_pkg::BASE_DEC) && value_word[WORD_BITS-1];
	assign magnitude = is_neg ? ('0 - value_word) : value_word;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		div_cmd.load  = 1'b0;
		div_cmd.again = 1'b0;
		ram_we        = 1'b0;
		out_load      = 1'b0;
		out_char      = itoar_pkg::digit_char(ram_rdata);
		out_last      = (count_q == CNT_W'(1));
		unique case (state_q)
			itoar_pkg::S_IDLE: begin
				if (accept) begin
					div_cmd.load = 1'b1;
					count_d      = '0;
					state_d      = itoar_pkg::S_DIV;
				end
			end
			itoar_pkg::S_DIV: begin
				if (div_stat.done) begin
					ram_we  = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (div_stat.quot_zero || count_q == CNT_W'(WORD_BITS - 1)) begin
						state_d = neg_q ? itoar_pkg::S_SIGN : itoar_pkg::S_RD;
					end else begin
						div_cmd.again = 1'b1;
					end
				end
			end
			itoar_pkg::S_SIGN: begin
				out_char = itoar_pkg::CHAR_MINUS;
				out_last = 1'b0;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = itoar_pkg::S_RD;
				end
			end
			itoar_pkg::S_RD: begin
				state_d = itoar_pkg::S_EMIT;
			end
			itoar_pkg::S_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					count_d  = count_dec;
					state_d  = (count_q == CNT_W'(1)) ? itoar_pkg::S_IDLE : itoar_pkg::S_RD;
				end
			end
			default: begin
				state_d = itoar_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoar_pkg::S_IDLE;
			count_q     <= '0;
			neg_q       <= 1'b0;
			base_q      <= itoar_pkg::BASE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (accept) begin
				neg_q <= is_neg;
			end
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the character while the receiver stalls
	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	itoar_div #(
		.WORD_BITS(WORD_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.dividend  (magnitude),
		.divisor   (eff_base),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	itoar_ram #(
		.WIDTH(itoar_pkg::DIGIT_BITS),
		.DEPTH(WORD_BITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (div_rem),
		.raddr (count_dec[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

`ifndef SYNTH
	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itoar_pkg::S_EMIT) |-> (count_q != '0))
		else $error("emit state with empty digit count");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == itoar_pkg::S_DIV))
		else $error("divider finished outside the divide state");

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == itoar_pkg::S_DIV))
		else $error("accepted word did not start a division");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last) |=> (state_q == itoar_pkg::S_IDLE))
		else $error("last character loaded but conversion not finished");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WORD_BITS))
		else $error("digit count beyond store depth");
`endif

endmodule
